FILE: sv/gvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_pkg
// Shared types and constants of the GARCH(1,1) volatility signal block.
// ----------------------------------------------------------------------------
package gvs_pkg;

   // Widest day count that the item format carries.
   localparam int DAYS_MAX_W = 16;
   localparam int DAYS_IDX_W = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LRV       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DAYS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DAYS  = 3'd6;

   // Reset values of the registers.
   localparam logic [47:0] OMEGA_RST     = 48'd281475;
   localparam logic [15:0] ALPHA_RST     = 16'd6554;
   localparam logic [15:0] BETA_RST      = 16'd55706;
   localparam logic [47:0] LRV_RST       = 48'd5629500;
   localparam logic [22:0] THRESHOLD_RST = 23'd6554;
   localparam logic [9:0]  MIN_DAYS_RST  = 10'd0;
   localparam logic [9:0]  MAX_DAYS_RST  = 10'd1023;

   localparam logic [63:0] LN2_Q30   = 64'd744261118;
   localparam logic [63:0] VOL_GATE  = 64'd28147497672;
   localparam logic [63:0] POW_CAP   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] PROD_CAP  = 64'h0002_0000_0000_0000;
   localparam logic [63:0] ROOT_CAP  = 64'h0100_0000_0000_0000;
   localparam logic [34:0] DIFF_CAP  = 35'h0_C000_0000;
   localparam logic [23:0] SIG_MAX   = 24'd8388607;
   localparam logic [23:0] SIG_MIN_M = 24'd8388608;
   localparam logic [16:0] UNIT_Q16  = 17'd65536;
   localparam logic [16:0] UNIT_TOL  = 17'd65;

   typedef struct packed {
      logic [47:0] omega;
      logic [15:0] alpha;
      logic [15:0] beta;
      logic [47:0] lrv;
      logic [22:0] threshold;
      logic [9:0]  min_days;
      logic [9:0]  max_days;
   } cfg_type;

   typedef struct packed {
      logic                  kind;
      logic [31:0]           price;
      logic [DAYS_MAX_W-1:0] days;
      logic [15:0]           iv;
   } item_type;

   typedef enum logic [4:0] {
      S_IDLE, S_PRICE, S_LOG, S_LOG_W, S_DIFF, S_DIFF_W, S_SQ, S_SQ_W,
      S_TA, S_TA_W, S_TB, S_TB_W, S_OPT, S_POW_SQ, S_POW_SQ_W, S_POW_MB,
      S_POW_MB_W, S_FV, S_FV_W, S_ANN, S_SQRT, S_QSET, S_DIV, S_RES
   } state_type;

endpackage

FILE: sv/gvs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_front
// Accepts items, drops option items outside the day window or without an
// implied volatility, and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module gvs_front #(
   parameter int DAY_BITS = 10
) (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [31:0]         req_price,
   input  logic [DAY_BITS-1:0] req_days_to_expiry,
   input  logic [15:0]         req_implied_vol,
   input  gvs_pkg::cfg_type    cfg,
   input  logic                q_full,
   output logic                q_push,
   output gvs_pkg::item_type   q_item
);
   import gvs_pkg::*;

   logic [DAYS_MAX_W-1:0] days_ext;
   logic                  opt_ok;

   assign days_ext = DAYS_MAX_W'(req_days_to_expiry);

   // An option is only worth evaluating inside the window and with a quote.
   assign opt_ok = (days_ext >= DAYS_MAX_W'(cfg.min_days)) &&
                   (days_ext <= DAYS_MAX_W'(cfg.max_days)) &&
                   (req_implied_vol != 16'd0);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && (!req_kind || opt_ok);

   always_comb begin
      q_item.kind  = req_kind;
      q_item.price = req_price;
      q_item.days  = days_ext;
      q_item.iv    = req_implied_vol;
   end

endmodule

FILE: sv/gvs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module gvs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gvs_pkg::item_type push_item,
   input  logic              pop,
   output gvs_pkg::item_type head_item,
   output logic              full,
   output logic              empty
);
   import gvs_pkg::*;

   item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/gvs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_mul
// 64 x 64 multiplier built from one 32 x 32 multiplier, one partial product
// per cycle. Narrow operands finish after a single partial product.
// ----------------------------------------------------------------------------
module gvs_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);
   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   step_ff, step_in;
   logic [1:0]   last_ff, last_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  a_sel, b_sel;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   always_comb begin
      a_sel = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_sel = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp    = a_sel * b_sel;
      unique case (step_ff)
         2'd0:    pp_sh = 128'(pp);
         2'd3:    pp_sh = 128'(pp) << 64;
         default: pp_sh = 128'(pp) << 32;
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      last_in = last_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         step_in = 2'd0;
         last_in = ((a[63:32] == 32'd0) && (b[63:32] == 32'd0)) ? 2'd0 : 2'd3;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         if (step_ff == last_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      last_ff <= last_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

FILE: sv/gvs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_back
// Sequencer that carries out queued items: log return and variance update
// for prices, forecast, square root and relative difference for options.
// ----------------------------------------------------------------------------
module gvs_back #(
   parameter int DAY_BITS    = 10,
   parameter int ANNUAL_DAYS = 252
) (
   input  logic                clock,
   input  logic                reset,
   input  gvs_pkg::cfg_type    cfg,
   input  logic                q_empty,
   input  gvs_pkg::item_type   q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_sell_flag,
   output logic signed [23:0]  rsp_signal,
   output logic [31:0]         rsp_forecast_vol
);
   import gvs_pkg::*;

   localparam int AD_W = $clog2(ANNUAL_DAYS + 1);
   localparam int X_W  = 48 + AD_W;

   state_type state_ff, state_in;

   item_type    item_ff, item_in;
   logic [31:0] last_price_ff, last_price_in;
   logic [47:0] variance_ff, variance_in;
   logic [4:0]  e_ff, e_in;
   logic [31:0] m_ff, m_in;
   logic [29:0] frac_ff, frac_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        which_ff, which_in;
   logic [34:0] lp_ff, lp_in;
   logic [34:0] ll_ff, ll_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [63:0] r2_ff, r2_in;
   logic [50:0] ta_ff, ta_in;
   logic [63:0] pw_ff, pw_in;
   logic [DAYS_IDX_W-1:0] idx_ff, idx_in;
   logic [47:0] fvar_ff, fvar_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic [31:0] fv_ff, fv_in;
   logic        sell_ff, sell_in;
   logic [48:0] dvd_ff, dvd_in;
   logic [31:0] drem_ff, drem_in;
   logic [23:0] q_ff, q_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_sell_ff, rsp_sell_in;
   logic [23:0] rsp_signal_ff, rsp_signal_in;
   logic [31:0] rsp_fv_ff, rsp_fv_in;

   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_prod;
   logic         rsp_load;

   logic [X_W-1:0] x_gate, x_ann;
   logic           gate_ok, unit_root, var_up, days_bit, res_hit;
   logic [16:0]    p_sum, p_dev;
   logic [63:0]    base;
   logic [34:0]    d_raw, d_clip;
   logic [32:0]    sq_s;
   logic [63:0]    root_try;
   logic [32:0]    div_t;
   logic           div_ge;
   logic [48:0]    quot;
   logic [31:0]    iv28;

   // Leading-one normalization of a nonzero price: exponent and mantissa.
   function automatic logic [36:0] norm(input logic [31:0] x);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            e = 5'(i);
         end
      end
      return {e, x << (5'd31 - e)};
   endfunction

   // Q.32 product rounded half up, saturating at cap.
   function automatic logic [63:0] sat_q32(input logic [127:0] p, input logic [63:0] cap);
      logic [127:0] s;
      s = p + 128'h8000_0000;
      return ((s[127:96] != 32'd0) || (s[95:32] > cap)) ? cap : s[95:32];
   endfunction

   assign x_gate   = X_W'(variance_ff) * X_W'(ANNUAL_DAYS);
   assign x_ann    = X_W'(fvar_ff) * X_W'(ANNUAL_DAYS);
   assign gate_ok  = 64'(x_gate) >= VOL_GATE;
   assign p_sum    = 17'(cfg.alpha) + 17'(cfg.beta);
   assign p_dev    = (p_sum >= UNIT_Q16) ? p_sum - UNIT_Q16 : UNIT_Q16 - p_sum;
   assign unit_root = p_dev <= UNIT_TOL;
   assign base     = 64'(p_sum) << 16;
   assign var_up   = variance_ff >= cfg.lrv;
   assign days_bit = item_ff.days[idx_ff];
   assign d_raw    = (ll_ff > lp_ff) ? ll_ff - lp_ff : lp_ff - ll_ff;
   assign d_clip   = (d_raw > DIFF_CAP) ? DIFF_CAP : d_raw;
   assign sq_s     = mul_prod[63:31];
   assign root_try = root_ff + bit_ff;
   assign div_t    = {drem_ff, dvd_ff[48]};
   assign div_ge   = div_t >= {1'b0, fv_ff};
   assign quot     = {dvd_ff[47:0], div_ge};
   assign iv28     = {item_ff.iv, 16'd0};
   assign res_hit  = q_ff >= 24'(cfg.threshold);

   gvs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               state_in = q_item.kind ? S_OPT : S_PRICE;
            end
         end
         S_PRICE: begin
            if (last_price_ff == 32'd0) begin
               state_in = S_IDLE;
            end else if (item_ff.price == 32'd0) begin
               state_in = S_SQ;
            end else begin
               state_in = S_LOG;
            end
         end
         S_LOG: state_in = S_LOG_W;
         S_LOG_W: begin
            if (mul_done) begin
               state_in = (cnt_ff == 6'd29 && which_ff) ? S_DIFF : S_LOG;
            end
         end
         S_DIFF: state_in = S_DIFF_W;
         S_DIFF_W: if (mul_done) state_in = S_SQ;
         S_SQ: state_in = S_SQ_W;
         S_SQ_W: if (mul_done) state_in = S_TA;
         S_TA: state_in = S_TA_W;
         S_TA_W: if (mul_done) state_in = S_TB;
         S_TB: state_in = S_TB_W;
         S_TB_W: if (mul_done) state_in = S_IDLE;
         S_OPT: begin
            if (!gate_ok) begin
               state_in = S_IDLE;
            end else if (unit_root) begin
               state_in = S_ANN;
            end else begin
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: state_in = S_POW_SQ_W;
         S_POW_SQ_W: begin
            if (mul_done) begin
               if (days_bit) begin
                  state_in = S_POW_MB;
               end else begin
                  state_in = (idx_ff == '0) ? S_FV : S_POW_SQ;
               end
            end
         end
         S_POW_MB: state_in = S_POW_MB_W;
         S_POW_MB_W: begin
            if (mul_done) begin
               state_in = (idx_ff == '0) ? S_FV : S_POW_SQ;
            end
         end
         S_FV: state_in = S_FV_W;
         S_FV_W: if (mul_done) state_in = S_ANN;
         S_ANN: state_in = (64'(x_ann) >= ROOT_CAP) ? S_QSET : S_SQRT;
         S_SQRT: if (cnt_ff == 6'd31) state_in = S_QSET;
         S_QSET: state_in = (fv_ff == 32'd0) ? S_RES : S_DIV;
         S_DIV: if (cnt_ff == 6'd48) state_in = S_RES;
         S_RES: begin
            if (!res_hit || !rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs: queue pop, multiplier issue and result load.
   always_comb begin
      q_pop     = (state_ff == S_IDLE) && !q_empty;
      mul_start = 1'b0;
      mul_a     = 64'(m_ff);
      mul_b     = 64'(m_ff);
      rsp_load  = (state_ff == S_RES) && res_hit && (!rsp_valid_ff || !rsp_stall);
      unique case (state_ff)
         S_LOG: begin
            mul_start = 1'b1;
         end
         S_DIFF: begin
            mul_start = 1'b1;
            mul_a     = 64'(d_clip);
            mul_b     = LN2_Q30;
         end
         S_SQ: begin
            mul_start = 1'b1;
            mul_a     = 64'(mag_ff);
            mul_b     = 64'(mag_ff);
         end
         S_TA: begin
            mul_start = 1'b1;
            mul_a     = 64'(cfg.alpha);
            mul_b     = r2_ff;
         end
         S_TB: begin
            mul_start = 1'b1;
            mul_a     = 64'(cfg.beta);
            mul_b     = 64'(variance_ff);
         end
         S_POW_SQ: begin
            mul_start = 1'b1;
            mul_a     = pw_ff;
            mul_b     = pw_ff;
         end
         S_POW_MB: begin
            mul_start = 1'b1;
            mul_a     = pw_ff;
            mul_b     = base;
         end
         S_FV: begin
            mul_start = 1'b1;
            mul_a     = pw_ff;
            mul_b     = var_up ? 64'(variance_ff - cfg.lrv) : 64'(cfg.lrv - variance_ff);
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      logic [36:0]  nm;
      logic [29:0]  frac_n;
      logic [33:0]  rnd;
      logic [52:0]  vsum;
      logic [49:0]  fmag;
      logic [50:0]  fsum;
      logic [63:0]  rem_n, root_n;
      logic [31:0]  num;

      item_in       = item_ff;
      last_price_in = last_price_ff;
      variance_in   = variance_ff;
      e_in          = e_ff;
      m_in          = m_ff;
      frac_in       = frac_ff;
      cnt_in        = cnt_ff;
      which_in      = which_ff;
      lp_in         = lp_ff;
      ll_in         = ll_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      r2_in         = r2_ff;
      ta_in         = ta_ff;
      pw_in         = pw_ff;
      idx_in        = idx_ff;
      fvar_in       = fvar_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      fv_in         = fv_ff;
      sell_in       = sell_ff;
      dvd_in        = dvd_ff;
      drem_in       = drem_ff;
      q_in          = q_ff;
      rsp_sell_in   = rsp_sell_ff;
      rsp_signal_in = rsp_signal_ff;
      rsp_fv_in     = rsp_fv_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      nm     = norm(item_ff.price);
      frac_n = {frac_ff[28:0], sq_s[32]};
      rnd    = mul_prod[63:30] + 34'd0;
      vsum   = '0;
      fmag   = '0;
      fsum   = '0;
      rem_n  = rem_ff;
      root_n = root_ff >> 1;
      num    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               item_in = q_item;
            end
         end
         S_PRICE: begin
            if (last_price_ff == 32'd0) begin
               last_price_in = item_ff.price;
            end else if (item_ff.price == 32'd0) begin
               mag_in = 32'h8000_0000;
            end else begin
               e_in     = nm[36:32];
               m_in     = nm[31:0];
               frac_in  = '0;
               cnt_in   = '0;
               which_in = 1'b0;
            end
         end
         S_LOG_W: begin
            if (mul_done) begin
               if (cnt_ff == 6'd29) begin
                  if (!which_ff) begin
                     nm       = norm(last_price_ff);
                     lp_in    = {e_ff, frac_n};
                     e_in     = nm[36:32];
                     m_in     = nm[31:0];
                     frac_in  = '0;
                     cnt_in   = '0;
                     which_in = 1'b1;
                  end else begin
                     ll_in = {e_ff, frac_n};
                  end
               end else begin
                  m_in    = sq_s[32] ? sq_s[32:1] : sq_s[31:0];
                  frac_in = frac_n;
                  cnt_in  = cnt_ff + 6'd1;
               end
            end
         end
         S_DIFF: begin
            neg_in = ll_ff > lp_ff;
         end
         S_DIFF_W: begin
            if (mul_done) begin
               // Round half away from zero on the magnitude, then saturate.
               rnd = 34'((mul_prod[63:0] + 64'h2000_0000) >> 30);
               if (!neg_ff && rnd > 34'h0_7FFF_FFFF) begin
                  mag_in = 32'h7FFF_FFFF;
               end else if (neg_ff && rnd > 34'h0_8000_0000) begin
                  mag_in = 32'h8000_0000;
               end else begin
                  mag_in = rnd[31:0];
               end
            end
         end
         S_SQ_W: begin
            if (mul_done) begin
               r2_in = mul_prod[63:0];
            end
         end
         S_TA_W: begin
            if (mul_done) begin
               ta_in = 51'((mul_prod + 128'h800_0000) >> 28);
            end
         end
         S_TB_W: begin
            if (mul_done) begin
               vsum = 53'(cfg.omega) + 53'(ta_ff) +
                      53'((mul_prod + 128'h8000) >> 16);
               variance_in   = (vsum[52:48] != 5'd0) ? 48'hFFFF_FFFF_FFFF : vsum[47:0];
               last_price_in = item_ff.price;
            end
         end
         S_OPT: begin
            pw_in   = 64'h1_0000_0000;
            idx_in  = DAYS_IDX_W'(DAY_BITS - 1);
            fvar_in = variance_ff;
         end
         S_POW_SQ_W: begin
            if (mul_done) begin
               pw_in = sat_q32(mul_prod, POW_CAP);
               if (!days_bit && idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         S_POW_MB_W: begin
            if (mul_done) begin
               pw_in = sat_q32(mul_prod, POW_CAP);
               if (idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         S_FV: begin
            neg_in = !var_up;
         end
         S_FV_W: begin
            if (mul_done) begin
               fmag = 50'(sat_q32(mul_prod, PROD_CAP));
               if (!neg_ff) begin
                  fsum    = 51'(fmag) + 51'(cfg.lrv);
                  fvar_in = (fsum[50:48] != 3'd0) ? 48'hFFFF_FFFF_FFFF : fsum[47:0];
               end else begin
                  fvar_in = (fmag >= 50'(cfg.lrv)) ? 48'd0 : cfg.lrv - fmag[47:0];
               end
            end
         end
         S_ANN: begin
            if (64'(x_ann) >= ROOT_CAP) begin
               fv_in = 32'hFFFF_FFFF;
            end else begin
               rem_in  = 64'(x_ann) << 8;
               root_in = '0;
               bit_in  = 64'h4000_0000_0000_0000;
               cnt_in  = '0;
            end
         end
         S_SQRT: begin
            if (rem_ff >= root_try) begin
               rem_n  = rem_ff - root_try;
               root_n = (root_ff >> 1) + bit_ff;
            end
            rem_in  = rem_n;
            root_in = root_n;
            bit_in  = bit_ff >> 2;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               fv_in = root_n[31:0];
            end
         end
         S_QSET: begin
            if (fv_ff == 32'd0) begin
               sell_in = 1'b1;
               q_in    = SIG_MAX;
            end else begin
               sell_in = iv28 > fv_ff;
               num     = (iv28 > fv_ff) ? iv28 - fv_ff : fv_ff - iv28;
               dvd_in  = (49'(num) << 16) + 49'(fv_ff >> 1);
               drem_in = '0;
               cnt_in  = '0;
            end
         end
         S_DIV: begin
            drem_in = div_ge ? 32'(div_t - 33'(fv_ff)) : div_t[31:0];
            dvd_in  = quot;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) begin
               if (sell_ff) begin
                  q_in = (quot > 49'(SIG_MAX)) ? SIG_MAX : quot[23:0];
               end else begin
                  q_in = (quot > 49'(SIG_MIN_M)) ? SIG_MIN_M : quot[23:0];
               end
            end
         end
         S_RES: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_sell_in   = sell_ff;
               rsp_signal_in = sell_ff ? q_ff : 24'd0 - q_ff;
               rsp_fv_in     = fv_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_price_ff <= 32'd0;
         variance_ff   <= LRV_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_price_ff <= last_price_in;
         variance_ff   <= variance_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      e_ff          <= e_in;
      m_ff          <= m_in;
      frac_ff       <= frac_in;
      cnt_ff        <= cnt_in;
      which_ff      <= which_in;
      lp_ff         <= lp_in;
      ll_ff         <= ll_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      r2_ff         <= r2_in;
      ta_ff         <= ta_in;
      pw_ff         <= pw_in;
      idx_ff        <= idx_in;
      fvar_ff       <= fvar_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      fv_ff         <= fv_in;
      sell_ff       <= sell_in;
      dvd_ff        <= dvd_in;
      drem_ff       <= drem_in;
      q_ff          <= q_in;
      rsp_sell_ff   <= rsp_sell_in;
      rsp_signal_ff <= rsp_signal_in;
      rsp_fv_ff     <= rsp_fv_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sell_flag    = rsp_sell_ff;
   assign rsp_signal       = rsp_signal_ff;
   assign rsp_forecast_vol = rsp_fv_ff;

   // A multiplier result must land in a state that waits for it.
   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_LOG_W || state_ff == S_DIFF_W ||
                    state_ff == S_SQ_W || state_ff == S_TA_W ||
                    state_ff == S_TB_W || state_ff == S_POW_SQ_W ||
                    state_ff == S_POW_MB_W || state_ff == S_FV_W))
      else $error("multiplier result arrived outside a wait state");

   // The power term never exceeds its saturation value.
   a_pow_capped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POW_SQ || state_ff == S_POW_MB || state_ff == S_FV) |->
      (pw_ff <= POW_CAP))
      else $error("power term above its cap");

   // The root has consumed every bit position when it finishes.
   a_sqrt_last_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT && cnt_ff == 6'd31) |-> (bit_ff == 64'd1))
      else $error("square root step count out of line");

   // Variance only moves at the end of a price update.
   a_var_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(variance_ff)) |-> ($past(state_ff) == S_TB_W))
      else $error("variance changed outside the update step");

endmodule

FILE: sv/garch_vol_signal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// garch_vol_signal_top
// GARCH(1,1) volatility forecast and implied-versus-forecast trade signal.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the req_ channel (valid/stall). A price item (kind 0)
// updates the stored price and the GARCH(1,1) variance and gives no result.
// An option item (kind 1) gives at most one result on the rsp_ channel: the
// buy/sell flag, the relative difference in Q8.16 and the annualized
// forecast volatility in Q4.28.
// The front checks the day window and the implied volatility and drops
// options that fail; the rest wait in a two-item queue for the back.
// A price item's run time is set by the two 30-step log2 iterations on the
// shared multiplier. An option item that the volatility gate rejects returns
// to idle from the gate check; otherwise its run time is set by the
// square-and-multiply power over DAY_BITS day bits (4 partial
// products per 64-bit product on one 32 x 32 multiplier), the 32-step square
// root and the 49-step divider. Items are worked one at a time; the front
// keeps accepting while the queue has room.
// Reset (synchronous, active high) resets the configuration, sequencer state,
// last price, result valid, queue and variance (to the long-run variance).
// While rsp_stall is high the result holds in the output register; the back
// holds a next result in its last step; the queue fills before req_stall rises.
// Configuration is written through csr_ while the block is idle.
// ----------------------------------------------------------------------------
module garch_vol_signal_top #(
   parameter int DAY_BITS    = 10,
   parameter int ANNUAL_DAYS = 252
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [31:0]                        req_price,
   input  logic [DAY_BITS-1:0]                req_days_to_expiry,
   input  logic [15:0]                        req_implied_vol,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_sell_flag,
   output logic signed [23:0]                 rsp_signal,
   output logic [31:0]                        rsp_forecast_vol,
   input  logic                               csr_write_enable,
   input  logic [gvs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gvs_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import gvs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type push_item, head_item;
   logic     q_push, q_pop, q_full, q_empty;

   // Register file: each index writes its own field, unknown indexes do nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OMEGA:     cfg_in.omega     = csr_write_data[47:0];
            CSR_ALPHA:     cfg_in.alpha     = csr_write_data[15:0];
            CSR_BETA:      cfg_in.beta      = csr_write_data[15:0];
            CSR_LRV:       cfg_in.lrv       = csr_write_data[47:0];
            CSR_THRESHOLD: cfg_in.threshold = csr_write_data[22:0];
            CSR_MIN_DAYS:  cfg_in.min_days  = csr_write_data[9:0];
            CSR_MAX_DAYS:  cfg_in.max_days  = csr_write_data[9:0];
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.omega     <= OMEGA_RST;
         cfg_ff.alpha     <= ALPHA_RST;
         cfg_ff.beta      <= BETA_RST;
         cfg_ff.lrv       <= LRV_RST;
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.min_days  <= MIN_DAYS_RST;
         cfg_ff.max_days  <= MAX_DAYS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify items.
   gvs_front #(
      .DAY_BITS (DAY_BITS)
   ) u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_price          (req_price),
      .req_days_to_expiry (req_days_to_expiry),
      .req_implied_vol    (req_implied_vol),
      .cfg                (cfg_ff),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (push_item)
   );

   // Queue that decouples the front from the back.
   gvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: the arithmetic sequencer and the result register.
   gvs_back #(
      .DAY_BITS    (DAY_BITS),
      .ANNUAL_DAYS (ANNUAL_DAYS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_item           (head_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sell_flag    (rsp_sell_flag),
      .rsp_signal       (rsp_signal),
      .rsp_forecast_vol (rsp_forecast_vol)
   );

endmodule

FILE: dv/tb_garch_vol_signal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_garch_vol_signal_top
// Self-checking bench for the GARCH(1,1) volatility signal block.
// ----------------------------------------------------------------------------
// Price and option items are queued by the stimulus process and presented
// by a clocked driver with random gaps. A clocked monitor runs every accepted
// item through a bit-exact fixed-point forecaster and compares each result
// with the oldest forecast. Configuration changes between phases, once the
// block has drained.
// ----------------------------------------------------------------------------
module tb_garch_vol_signal_top;
   import gvs_pkg::*;

   localparam bit KIND_PRICE  = 1'b0;
   localparam bit KIND_OPTION = 1'b1;
   localparam int DRAIN_CYCLES = 2000;

   typedef struct {
      bit        kind;
      bit [31:0] price;
      bit [9:0]  days;
      bit [15:0] iv;
   } quote_type;

   typedef struct {
      bit        sell;
      bit [23:0] sig;
      bit [31:0] fv;
   } trade_sig_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [31:0] req_price = '0;
   logic [9:0]  req_days_to_expiry = '0;
   logic [15:0] req_implied_vol = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_sell_flag;
   logic signed [23:0] rsp_signal;
   logic [31:0] rsp_forecast_vol;
   logic        csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   garch_vol_signal_top u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model copy of the registers and the block state.
   bit [47:0] m_omega = OMEGA_RST, m_lrv = LRV_RST, model_var = LRV_RST;
   bit [15:0] m_alpha = ALPHA_RST, m_beta = BETA_RST;
   bit [22:0] m_thresh = THRESHOLD_RST;
   bit [9:0]  m_min_days = MIN_DAYS_RST, m_max_days = MAX_DAYS_RST;
   bit [31:0] m_last_price = '0;

   quote_type     pending_quotes[$];
   trade_sig_type expected_signals[$];
   int  quotes_issued = 0, quotes_taken = 0, errors = 0;
   bit  req_taken = 1'b0, rsp_taken = 1'b0;
   bit  burst = 1'b0;
   int  gap_left = 0, hold_left = 0;

   // ------------------------------------------------------------------------
   // Fixed-point forecaster.
   // ------------------------------------------------------------------------
   function automatic bit [63:0] mul_q32_sat(bit [63:0] x, bit [63:0] y, bit [63:0] cap);
      bit [127:0] p;
      bit [63:0]  r;
      p = x * y + 128'h8000_0000;
      if (p[127:96] != 0) return cap;
      r = p[95:32];
      return (r > cap) ? cap : r;
   endfunction

   function automatic bit [63:0] log2_q30(bit [31:0] x);
      bit [63:0] m, frac;
      int e;
      e = 31;
      frac = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      m = (64'(x) << (31 - e)) & 64'hFFFF_FFFF;
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(e) << 30) | frac;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // GARCH update on a new price; the first price after a zero is only stored.
   function automatic void update_variance(bit [31:0] price);
      bit [63:0] mag, lp, ll, d, r2, ta, tb, v;
      bit neg;
      if (m_last_price == 0) begin
         m_last_price = price;
         return;
      end
      if (price == 0) begin
         mag = 64'h8000_0000;
      end else begin
         lp = log2_q30(price);
         ll = log2_q30(m_last_price);
         neg = ll > lp;
         d = neg ? ll - lp : lp - ll;
         if (d > (64'd3 << 30)) d = 64'd3 << 30;
         mag = (d * LN2_Q30 + (64'd1 << 29)) >> 30;
         if (!neg && mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
         if (neg && mag > 64'h8000_0000) mag = 64'h8000_0000;
      end
      r2 = mag * mag;
      ta = ((64'(m_alpha) * (r2 >> 32)) << 4)
         + ((64'(m_alpha) * (r2 & 64'hFFFF_FFFF) + (64'd1 << 27)) >> 28);
      tb = (64'(m_beta) * model_var + (64'd1 << 15)) >> 16;
      v = 64'(m_omega) + ta + tb;
      model_var = (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
      m_last_price = price;
   endfunction

   function automatic bit [63:0] forecast_variance(bit [9:0] days);
      bit [63:0] p, pw, base, mag;
      p = 64'(m_alpha) + 64'(m_beta);
      // Persistence close enough to one: the variance carries over unchanged.
      if (((p >= 65536) ? p - 65536 : 65536 - p) <= 65) return model_var;
      base = p << 16;
      pw = 64'd1 << 32;
      for (int i = 9; i >= 0; i--) begin
         pw = mul_q32_sat(pw, pw, POW_CAP);
         if (days[i]) pw = mul_q32_sat(pw, base, POW_CAP);
      end
      if (model_var >= m_lrv) begin
         mag = mul_q32_sat(pw, 64'(model_var - m_lrv), PROD_CAP) + m_lrv;
         return (mag > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : mag;
      end
      mag = mul_q32_sat(pw, 64'(m_lrv - model_var), PROD_CAP);
      return (mag >= m_lrv) ? 0 : m_lrv - mag;
   endfunction

   // Returns 1 when the item produces a trade signal.
   function automatic bit forecast_signal(quote_type q, output trade_sig_type s);
      bit [63:0] x, fv, iv28, num, mag;
      bit sell;
      s = '{default: 0};
      if (q.kind == KIND_PRICE) begin
         update_variance(q.price);
         return 0;
      end
      if (64'(model_var) * 252 < VOL_GATE) return 0;
      if (q.days < m_min_days || q.days > m_max_days) return 0;
      if (q.iv == 0) return 0;
      x = forecast_variance(q.days) * 252;
      fv = (x >= (64'd1 << 56)) ? 64'hFFFF_FFFF : int_sqrt(x << 8);
      iv28 = 64'(q.iv) << 16;
      if (fv == 0) begin
         sell = 1'b1;
         mag = 8388607;
      end else begin
         sell = iv28 > fv;
         num = sell ? iv28 - fv : fv - iv28;
         mag = ((num << 16) + (fv >> 1)) / fv;
         if (sell && mag > 8388607) mag = 8388607;
         if (!sell && mag > 8388608) mag = 8388608;
      end
      if (mag < m_thresh) return 0;
      s.sell = sell;
      s.sig = sell ? mag[23:0] : 24'((64'd1 << 24) - mag);
      s.fv = fv[31:0];
      return 1;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: presents queued items at the falling edge with random gaps.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      quote_type q;
      if (!reset && !(req_valid && !req_taken)) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_quotes.size() != 0) begin
            q = pending_quotes[0];
            pending_quotes.delete(0);
            req_kind <= q.kind;
            req_price <= q.price;
            req_days_to_expiry <= q.days;
            req_implied_vol <= q.iv;
            req_valid <= 1'b1;
            // Occasionally switch between back-to-back bursts and gappy traffic.
            if ($urandom_range(0, 99) == 0) burst = !burst;
            gap_left <= burst ? 0 : $urandom_range(0, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: a fresh stall length after each result.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) hold_left = burst ? 0 : $urandom_range(0, 4);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: forecasts each accepted item and checks each result.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      quote_type     q;
      trade_sig_type s, got;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) begin
         q = '{req_kind, req_price, req_days_to_expiry, req_implied_vol};
         quotes_taken++;
         if (forecast_signal(q, s)) expected_signals.insert(expected_signals.size(), s);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_sell_flag, rsp_signal, rsp_forecast_vol};
         if (expected_signals.size() == 0) begin
            errors++;
            $display("%0t: unexpected result sell=%0d signal=%0h fv=%0h",
                     $time, got.sell, got.sig, got.fv);
         end else begin
            s = expected_signals[0];
            expected_signals.delete(0);
            if (got.sell !== s.sell) begin
               errors++;
               $display("%0t: sell_flag expected %0d actual %0d", $time, s.sell, got.sell);
            end
            if (got.sig !== s.sig) begin
               errors++;
               $display("%0t: signal expected %0h actual %0h", $time, s.sig, got.sig);
            end
            if (got.fv !== s.fv) begin
               errors++;
               $display("%0t: forecast_vol expected %0h actual %0h", $time, s.fv, got.fv);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   bit [31:0] gen_price = 32'd1_000_000;

   task automatic push_quote(bit kind, bit [31:0] price, bit [9:0] days, bit [15:0] iv);
      quote_type q;
      q = '{kind, price, days, iv};
      pending_quotes.insert(pending_quotes.size(), q);
      quotes_issued++;
   endtask

   // Register writes happen only while the block is drained.
   task automatic write_csr(bit [CSR_IDX_W-1:0] idx, bit [47:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_OMEGA:     m_omega = value;
         CSR_ALPHA:     m_alpha = value[15:0];
         CSR_BETA:      m_beta = value[15:0];
         CSR_LRV:       m_lrv = value;
         CSR_THRESHOLD: m_thresh = value[22:0];
         CSR_MIN_DAYS:  m_min_days = value[9:0];
         CSR_MAX_DAYS:  m_max_days = value[9:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(bit [47:0] omega, bit [15:0] alpha, bit [15:0] beta,
                            bit [47:0] lrv, bit [22:0] thresh, bit [9:0] lo, bit [9:0] hi);
      write_csr(CSR_OMEGA, omega);
      write_csr(CSR_ALPHA, 48'(alpha));
      write_csr(CSR_BETA, 48'(beta));
      write_csr(CSR_LRV, lrv);
      write_csr(CSR_THRESHOLD, 48'(thresh));
      write_csr(CSR_MIN_DAYS, 48'(lo));
      write_csr(CSR_MAX_DAYS, 48'(hi));
   endtask

   task automatic drain();
      wait (quotes_taken == quotes_issued);
      wait (expected_signals.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly small moves of a price walk, with jumps, zeros and tiny prices.
   task automatic random_quotes(int count);
      int pick;
      bit [31:0] step;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 75 && gen_price > 16) begin
               step = gen_price >> $urandom_range(3, 12);
               gen_price = $urandom_range(0, 1) ? gen_price + step : gen_price - step;
            end else if (pick < 90) begin
               gen_price = $urandom;
            end else if (pick < 95) begin
               gen_price = $urandom_range(0, 20);
            end else begin
               gen_price = 0;
            end
            push_quote(KIND_PRICE, gen_price, 10'($urandom), 16'($urandom));
         end else begin
            push_quote(KIND_OPTION, $urandom, 10'($urandom_range(0, 1023)),
                       16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096)));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under reset values: first price, extreme jumps both ways,
      // a zero price and the restart after it, then option edge cases.
      push_quote(KIND_PRICE, 32'd1_000_000, 10'd0, 16'd0);
      push_quote(KIND_PRICE, 32'hFFFF_FFFF, 10'd0, 16'd0);
      push_quote(KIND_OPTION, 32'd0, 10'd0, 16'hFFFF);
      push_quote(KIND_OPTION, 32'd0, 10'd1023, 16'd1);
      push_quote(KIND_OPTION, 32'd0, 10'd512, 16'd0);
      push_quote(KIND_PRICE, 32'd1, 10'd0, 16'd0);
      push_quote(KIND_OPTION, 32'hFFFF_FFFF, 10'h155, 16'hAAAA);
      push_quote(KIND_PRICE, 32'd0, 10'd0, 16'd0);
      push_quote(KIND_OPTION, 32'd0, 10'h2AA, 16'h5555);
      push_quote(KIND_PRICE, 32'd5, 10'd0, 16'd0);
      push_quote(KIND_PRICE, 32'h8000_0000, 10'd0, 16'd0);
      push_quote(KIND_PRICE, 32'h7FFF_FFFF, 10'd0, 16'd0);
      push_quote(KIND_OPTION, 32'd0, 10'd1, 16'd4096);
      push_quote(KIND_OPTION, 32'd0, 10'd30, 16'd600);
      push_quote(KIND_PRICE, 32'h7FFF_FFFF, 10'd0, 16'd0);
      push_quote(KIND_OPTION, 32'd0, 10'd0, 16'd1);
      random_quotes(300);
      drain();

      // Typical market settings with a narrow day window.
      configure(48'd281474977, 16'd6554, 16'd55706, 48'd5629499534, 23'd3277, 10'd1, 10'd500);
      random_quotes(550);
      drain();

      // Largest weights and constant term, zero long-run variance, no threshold.
      configure(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 48'd0, 23'd0, 10'd0, 10'd1023);
      random_quotes(200);
      drain();

      // Unit-root persistence, largest long-run variance and threshold,
      // a one-day window at the top.
      configure(48'd0, 16'd6554, 16'd58982, 48'hFFFF_FFFF_FFFF, 23'h7F_FFFF,
                10'd1023, 10'd1023);
      random_quotes(150);
      drain();

      // Zero weights and an empty day window.
      configure(48'h100_0000_0000, 16'd0, 16'd0, 48'h1000_0000_0000, 23'd655360,
                10'd600, 10'd100);
      random_quotes(100);
      drain();

      // Moderate persistence, every option that passes the gates reports.
      configure(48'd2814750, 16'd30000, 16'd30000, 48'd1000000000, 23'd0, 10'd0, 10'd1023);
      random_quotes(650);
      drain();

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: files.f
sv/gvs_pkg.sv
sv/gvs_front.sv
sv/gvs_queue.sv
sv/gvs_mul.sv
sv/gvs_back.sv
sv/garch_vol_signal_top.sv
dv/tb_garch_vol_signal_top.sv
